[rtl/spq_pkg.sv]
package spq_pkg;

  localparam int CAPACITY = 32;
  localparam int ID_BITS  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [7:0] TYPE_BEST = 8'h73;  // 's'
  localparam logic [7:0] TYPE_MID  = 8'h6E;  // 'n'

  localparam logic [1:0] KIND_INSERTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_LISTED   = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LIST   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] entry_id;
    logic [7:0]  type_code;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_id;
    logic [7:0]  out_type;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [7:0]         type_code;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               ins;
    logic               rot;
    logic [1:0]         cls;
    logic [ID_BITS-1:0] id;
    logic [7:0]         type_code;
  } cell_ctl_t;

  function automatic logic [1:0] class_of(input logic [7:0] t);
    logic [1:0] c;
    if (t == TYPE_BEST) begin
      c = 2'd1;
    end else if (t == TYPE_MID) begin
      c = 2'd2;
    end else begin
      c = 2'd3;
    end
    return c;
  endfunction

endpackage

[rtl/spq_cell.sv]
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               prev_before_i,
  input  logic               next_occ_i,
  input  spq_pkg::entry_t    prev_i,
  input  spq_pkg::entry_t    next_i,
  input  spq_pkg::entry_t    head_i,
  output spq_pkg::entry_t    entry_o,
  output logic               before_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // new entry belongs at or ahead of this slot
  assign before_o = !occ_i || (ctl_i.cls < class_of(entry_q.type_code));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (before_o) begin
        if (prev_before_i) begin
          entry_d = prev_i;
        end else begin
          entry_d.id        = ctl_i.id;
          entry_d.type_code = ctl_i.type_code;
        end
      end
    end else if (ctl_i.rot && occ_i) begin
      // rotate occupied slots by one: the head wraps to the tail
      entry_d = next_occ_i ? next_i : head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/stable_three_level_priority_queue.sv]
// Channel | Dir | Handshake              | Payload
// in      | in  | in_valid_i / in_stall_o | in_req_i  (operation, entry_id, type_code)
// out     | out | out_valid_o/ out_stall_i| out_res_o (kind, out_id, out_type, last)
//
// Insert: enters the cell chain if not full; the status result is registered and the
//   next request is taken as soon as that result has left or is leaving.
// List of n entries: the rotate state gives one entry per cycle, paced
//   by out_stall_i; an empty store answers nothing.
// Reset clears the count and control only; cell contents are left as they are.
// A stalled output holds its result; input stalls while listing or while a
//   result waits.
module stable_three_level_priority_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::out_res_t out_res_o
);
  import spq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  out_res_t         out_res_q, out_res_d;

  logic      in_fire, out_free, full;
  cell_ctl_t ctl;

  entry_t          cells [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ahead;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_LIST) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));

  // broadcast to the chain
  always_comb begin
    ctl.ins       = in_fire && (in_req_i.operation == OP_INSERT) && !full;
    ctl.rot       = (state_q == ST_LIST) && out_free;
    ctl.id        = ID_BITS'(in_req_i.entry_id);
    ctl.type_code = in_req_i.type_code;
    ctl.cls       = class_of(in_req_i.type_code);
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic   prev_before, next_occ;
      entry_t prev_e, next_e;

      assign occ[g] = (CNT_W'(g) < count_q);

      if (g == 0) begin : g_first
        assign prev_before = 1'b0;
        assign prev_e      = cells[0];
      end else begin : g_mid
        assign prev_before = ahead[g-1];
        assign prev_e      = cells[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign next_occ = 1'b0;
        assign next_e   = cells[0];
      end else begin : g_body
        assign next_occ = occ[g+1];
        assign next_e   = cells[g+1];
      end

      spq_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (ctl),
        .occ_i        (occ[g]),
        .prev_before_i(prev_before),
        .next_occ_i   (next_occ),
        .prev_i       (prev_e),
        .next_i       (next_e),
        .head_i       (cells[0]),
        .entry_o      (cells[g]),
        .before_o     (ahead[g])
      );
    end
  endgenerate

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_i.operation == OP_INSERT) begin
            out_valid_d     = 1'b1;
            out_res_d       = '0;
            out_res_d.last  = 1'b1;
            out_res_d.kind  = full ? KIND_FULL : KIND_INSERTED;
            if (!full) begin
              count_d = count_q + CNT_W'(1);
            end
          end else if (count_q != '0) begin
            rem_d   = count_q;
            state_d = ST_LIST;
          end
        end
      end
      ST_LIST: begin
        if (out_free) begin
          // head of the ring leaves; the chain rotates in the same cycle
          out_valid_d        = 1'b1;
          out_res_d.kind     = KIND_LISTED;
          out_res_d.out_id   = 16'(cells[0].id);
          out_res_d.out_type = cells[0].type_code;
          out_res_d.last     = (rem_q == CNT_W'(1));
          rem_d              = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

[rtl/spq_checker.sv]
module spq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input spq_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input spq_pkg::out_res_t out_res_o
);
  import spq_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_res_o))
    else $error("stalled result changed");

  a_insert_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.operation == OP_INSERT) |=>
      out_valid_o && out_res_o.last && (out_res_o.kind != KIND_LISTED))
    else $error("insert without status result");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.kind != KIND_LISTED) |->
      out_res_o.last && (out_res_o.out_id == '0) && (out_res_o.out_type == '0))
    else $error("malformed status result");

endmodule

bind stable_three_level_priority_queue spq_checker u_spq_checker (.*);
